/* rtl/rounded_rect_coverage_mask_assert.svh */
// ----------------------------------------------------------------------------
// rounded_rect_coverage_mask_assert.svh
// Assertion macros shared by the rounded rectangle coverage mask RTL
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_COVERAGE_MASK_ASSERT_SVH
`define ROUNDED_RECT_COVERAGE_MASK_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RRCM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, checked outside reset
`define RRCM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

/* rtl/rrcm_pkg.sv */
// ----------------------------------------------------------------------------
// rrcm_pkg
// Widths, constants and the beat type passed along the square root chain
// ----------------------------------------------------------------------------
package rrcm_pkg;

   // field widths
   localparam int CFG_W   = 13;
   localparam int PIX_W   = 12;
   localparam int COORD_W = PIX_W + 1;      // half-pixel coordinates
   localparam int QOFF_W  = COORD_W + 1;    // signed corner offsets
   localparam int SQ_W    = 2 * COORD_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int FRAC_W  = 8;              // fractional bits of the root
   localparam int ROOT_W  = 22;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int PAD_W   = RAD_W - SUM_W - 2 * FRAC_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int OFF_W   = QOFF_W + 1;     // inner distance minus radius
   localparam int DIST_W  = ROOT_W + 3;
   localparam int T_W     = FRAC_W + 2;
   localparam int COV_W   = 8;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   // geometry limits
   localparam int MAX_SIZE   = 4096;
   localparam int HALF_PIXEL = 1 << FRAC_W;
   localparam int NUM_CELLS  = ROOT_W;
   localparam int FRONT_STAGES = 6;

   // register indexes
   localparam logic [1:0] REG_MASK_WIDTH    = 2'd0;
   localparam logic [1:0] REG_MASK_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_CORNER_RADIUS = 2'd2;

   // one beat moving through the square root chain
   typedef struct packed {
      logic                     valid;
      logic [RAD_W-1:0]         radicand;
      logic [ROOT_W-1:0]        root;
      logic [REM_W-1:0]         rem;
      logic signed [OFF_W-1:0]  offset;
   } cell_beat_type;

endpackage

/* rtl/rounded_rect_coverage_mask.sv */
// ----------------------------------------------------------------------------
// rounded_rect_coverage_mask
// Anti-aliased coverage of a rounded rectangle filling a configured mask
// ----------------------------------------------------------------------------
// Usage:
//   Program mask_width, mask_height and corner_radius through the APB-style
//   port (byte addresses 0, 4, 8) while no pixel is in flight. The radius is
//   clamped to half the smaller side; sizes saturate at 4096, zero counts as 1.
//   Pixel beats enter on start with req_pixel_x / req_pixel_y; busy is never
//   raised, so one beat may be accepted every clock cycle.
//   Each beat gives exactly one rsp_coverage, marked by a one-cycle
//   rsp_valid strobe.
//   Results leave in input order. Throughput is one pixel per clock: six
//   geometry stages, a chain of 22 square root cells (one root bit each) and
//   one coverage stage, all fully pipelined.
//   Reset clears every stage valid bit, so no strobe follows reset, and puts
//   the registers back to width 1, height 1, radius 0.
//   The receiver cannot stall; rsp_valid must be taken when it is shown.
// ----------------------------------------------------------------------------
module rounded_rect_coverage_mask import rrcm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // pixel input
   input  logic               start,
   output logic               busy,
   input  logic [PIX_W-1:0]   req_pixel_x,
   input  logic [PIX_W-1:0]   req_pixel_y,
   // coverage result
   output logic               rsp_valid,
   output logic [COV_W-1:0]   rsp_coverage,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   logic [CFG_W-1:0]   width_ff, width_in;
   logic [CFG_W-1:0]   height_ff, height_in;
   logic [CFG_W-1:0]   radius_ff, radius_in;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic               accept;

   cell_beat_type      cell_link [NUM_CELLS+1];

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[ADDR_W-1 -: 2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MASK_WIDTH:    width_in  = pwdata[CFG_W-1:0];
            REG_MASK_HEIGHT:   height_in = pwdata[CFG_W-1:0];
            REG_CORNER_RADIUS: radius_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
         radius_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MASK_WIDTH:    prdata = {{(DATA_W - CFG_W){1'b0}}, width_ff};
         REG_MASK_HEIGHT:   prdata = {{(DATA_W - CFG_W){1'b0}}, height_ff};
         REG_CORNER_RADIUS: prdata = {{(DATA_W - CFG_W){1'b0}}, radius_ff};
         default:           prdata = '0;
      endcase
   end

   // fully pipelined, a beat can enter every cycle
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // geometry stages
   rrcm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .pixel_x       (req_pixel_x),
      .pixel_y       (req_pixel_y),
      .mask_width    (width_ff),
      .mask_height   (height_ff),
      .corner_radius (radius_ff),
      .cell_out      (cell_link[0])
   );

   // square root chain, one root bit per cell
   for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
      rrcm_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (cell_link[gi]),
         .cell_out (cell_link[gi+1])
      );
   end

   // coverage stage
   rrcm_coverage u_coverage (
      .clock        (clock),
      .reset        (reset),
      .cell_in      (cell_link[NUM_CELLS]),
      .rsp_valid    (rsp_valid),
      .rsp_coverage (rsp_coverage)
   );

endmodule

/* rtl/rrcm_front.sv */
// ----------------------------------------------------------------------------
// rrcm_front
// Geometry stages: half-pixel offsets from the corner centres and the radicand
// ----------------------------------------------------------------------------
module rrcm_front import rrcm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [PIX_W-1:0]    pixel_x,
   input  logic [PIX_W-1:0]    pixel_y,
   input  logic [CFG_W-1:0]    mask_width,
   input  logic [CFG_W-1:0]    mask_height,
   input  logic [CFG_W-1:0]    corner_radius,
   output cell_beat_type       cell_out
);

   logic [FRONT_STAGES-1:0]   valid_ff, valid_in;

   logic [CFG_W-1:0]          w_sat, h_sat, r_sat, m_min;
   logic [CFG_W:0]            r2_full;

   logic [COORD_W-1:0]        px1_ff, px1_in, py1_ff, py1_in;
   logic [CFG_W-1:0]          w1_ff, w1_in, h1_ff, h1_in, r21_ff, r21_in;

   logic [COORD_W-1:0]        ax2_ff, ax2_in, ay2_ff, ay2_in;
   logic [CFG_W-1:0]          wr2_ff, wr2_in, hr2_ff, hr2_in, r22_ff, r22_in;

   logic signed [QOFF_W-1:0]  qx3_ff, qx3_in, qy3_ff, qy3_in;
   logic [CFG_W-1:0]          r23_ff, r23_in;

   logic signed [QOFF_W-1:0]  qmax, inner;
   logic [COORD_W-1:0]        ox4_ff, ox4_in, oy4_ff, oy4_in;
   logic signed [OFF_W-1:0]   off4_ff, off4_in;

   logic [SQ_W-1:0]           oxsq5_ff, oxsq5_in, oysq5_ff, oysq5_in;
   logic signed [OFF_W-1:0]   off5_ff, off5_in;

   logic [SUM_W-1:0]          sq_sum;
   cell_beat_type             beat_ff, beat_in;

   // stage valid shift line
   assign valid_in = {valid_ff[FRONT_STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // saturated sizes and clamped doubled radius
   always_comb begin
      w_sat = (mask_width > CFG_W'(MAX_SIZE)) ? CFG_W'(MAX_SIZE) : mask_width;
      if (w_sat == '0) begin
         w_sat = CFG_W'(1);
      end
      h_sat = (mask_height > CFG_W'(MAX_SIZE)) ? CFG_W'(MAX_SIZE) : mask_height;
      if (h_sat == '0) begin
         h_sat = CFG_W'(1);
      end
      r_sat   = (corner_radius > CFG_W'(MAX_SIZE)) ? CFG_W'(MAX_SIZE) : corner_radius;
      m_min   = (w_sat < h_sat) ? w_sat : h_sat;
      r2_full = {r_sat, 1'b0};
   end

   // stage 1: pixel centres and sizes
   assign px1_in = {pixel_x, 1'b1};
   assign py1_in = {pixel_y, 1'b1};
   assign w1_in  = w_sat;
   assign h1_in  = h_sat;
   assign r21_in = (r2_full > {1'b0, m_min}) ? m_min : r2_full[CFG_W-1:0];

   // stage 2: distance from the mask centre and half the straight edge lengths
   assign ax2_in = (px1_ff >= w1_ff) ? (px1_ff - w1_ff) : (w1_ff - px1_ff);
   assign ay2_in = (py1_ff >= h1_ff) ? (py1_ff - h1_ff) : (h1_ff - py1_ff);
   assign wr2_in = w1_ff - r21_ff;
   assign hr2_in = h1_ff - r21_ff;
   assign r22_in = r21_ff;

   // stage 3: signed offsets from the corner circle centres
   assign qx3_in = $signed({1'b0, ax2_ff}) - $signed({1'b0, wr2_ff});
   assign qy3_in = $signed({1'b0, ay2_ff}) - $signed({1'b0, hr2_ff});
   assign r23_in = r22_ff;

   // stage 4: outer components and inner distance less the radius
   always_comb begin
      qmax   = (qx3_ff > qy3_ff) ? qx3_ff : qy3_ff;
      inner  = qmax[QOFF_W-1] ? qmax : '0;
      ox4_in = qx3_ff[QOFF_W-1] ? '0 : qx3_ff[COORD_W-1:0];
      oy4_in = qy3_ff[QOFF_W-1] ? '0 : qy3_ff[COORD_W-1:0];
      off4_in = OFF_W'(inner) - $signed({2'b00, r23_ff});
   end

   // stage 5: squares
   assign oxsq5_in = ox4_ff * ox4_ff;
   assign oysq5_in = oy4_ff * oy4_ff;
   assign off5_in  = off4_ff;

   // stage 6: radicand with fractional bits, seeds the root chain
   assign sq_sum = {1'b0, oxsq5_ff} + {1'b0, oysq5_ff};

   always_comb begin
      beat_in.valid    = valid_ff[FRONT_STAGES-2];
      beat_in.radicand = {{PAD_W{1'b0}}, sq_sum, {(2 * FRAC_W){1'b0}}};
      beat_in.root     = '0;
      beat_in.rem      = '0;
      beat_in.offset   = off5_ff;
   end

   // payload registers
   always_ff @(posedge clock) begin
      px1_ff   <= px1_in;
      py1_ff   <= py1_in;
      w1_ff    <= w1_in;
      h1_ff    <= h1_in;
      r21_ff   <= r21_in;
      ax2_ff   <= ax2_in;
      ay2_ff   <= ay2_in;
      wr2_ff   <= wr2_in;
      hr2_ff   <= hr2_in;
      r22_ff   <= r22_in;
      qx3_ff   <= qx3_in;
      qy3_ff   <= qy3_in;
      r23_ff   <= r23_in;
      ox4_ff   <= ox4_in;
      oy4_ff   <= oy4_in;
      off4_ff  <= off4_in;
      oxsq5_ff <= oxsq5_in;
      oysq5_ff <= oysq5_in;
      off5_ff  <= off5_in;
      beat_ff  <= beat_in;
   end

   always_comb begin
      cell_out       = beat_ff;
      cell_out.valid = valid_ff[FRONT_STAGES-1];
   end

endmodule

/* rtl/rrcm_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rrcm_sqrt_cell
// One restoring square root step: takes two radicand bits, yields one root bit
// ----------------------------------------------------------------------------
module rrcm_sqrt_cell import rrcm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cell_beat_type  cell_in,
   output cell_beat_type  cell_out
);

`include "rounded_rect_coverage_mask_assert.svh"

   logic [REM_W+1:0]          rem_shift, trial, diff;
   logic                      fits;

   logic                      valid_ff, valid_in;
   logic [RAD_W-1:0]          radicand_ff, radicand_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic signed [OFF_W-1:0]   offset_ff, offset_in;

   // trial subtraction of 4*root + 1 from the shifted remainder
   always_comb begin
      rem_shift   = {cell_in.rem, cell_in.radicand[RAD_W-1 -: 2]};
      trial       = {{(REM_W - ROOT_W){1'b0}}, cell_in.root, 2'b01};
      fits        = (rem_shift >= trial);
      diff        = rem_shift - trial;
      valid_in    = cell_in.valid;
      radicand_in = {cell_in.radicand[RAD_W-3:0], 2'b00};
      root_in     = {cell_in.root[ROOT_W-2:0], fits};
      rem_in      = fits ? diff[REM_W-1:0] : rem_shift[REM_W-1:0];
      offset_in   = cell_in.offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      radicand_ff <= radicand_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      offset_ff   <= offset_in;
   end

   always_comb begin
      cell_out.valid    = valid_ff;
      cell_out.radicand = radicand_ff;
      cell_out.root     = root_ff;
      cell_out.rem      = rem_ff;
      cell_out.offset   = offset_ff;
   end

   // beats advance one cell per cycle
   `RRCM_ASSERT_NEXT(a_cell_valid_moves, clock, reset, cell_in.valid, cell_out.valid)
   // partial remainder never exceeds twice the partial root
   `RRCM_ASSERT_IMPLY(a_cell_rem_bound, clock, reset, cell_out.valid, ({1'b0, cell_out.rem} <= {2'b00, cell_out.root, 1'b0}))
   // distance offset rides along untouched
   `RRCM_ASSERT_NEXT(a_cell_offset_held, clock, reset, cell_in.valid, (cell_out.offset == $past(cell_in.offset)))

endmodule

/* rtl/rrcm_coverage.sv */
// ----------------------------------------------------------------------------
// rrcm_coverage
// Signed distance to coverage: clamp, scale by 255 and round
// ----------------------------------------------------------------------------
module rrcm_coverage import rrcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_beat_type     cell_in,
   output logic              rsp_valid,
   output logic [COV_W-1:0]  rsp_coverage
);

`include "rounded_rect_coverage_mask_assert.svh"

   logic signed [DIST_W-1:0]  distance, t_raw;
   logic [T_W-1:0]            t_clamp;
   logic [T_W+FRAC_W-1:0]     scaled;

   logic                      valid_ff, valid_in;
   logic [COV_W-1:0]          coverage_ff, coverage_in;

   // distance in half pixels, Q.8
   always_comb begin
      distance = $signed({3'b000, cell_in.root})
               + $signed({{(DIST_W - OFF_W - FRAC_W){cell_in.offset[OFF_W-1]}},
                          cell_in.offset, {FRAC_W{1'b0}}});
      t_raw = DIST_W'(HALF_PIXEL) - distance;
      priority if (t_raw[DIST_W-1]) begin
         t_clamp = '0;
      end else if (t_raw > DIST_W'(2 * HALF_PIXEL)) begin
         t_clamp = T_W'(2 * HALF_PIXEL);
      end else begin
         t_clamp = t_raw[T_W-1:0];
      end
      // t * 255 + half, then drop the nine fraction bits
      scaled = {t_clamp, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, t_clamp}
             + (T_W + FRAC_W)'(HALF_PIXEL);
      coverage_in = scaled[T_W+FRAC_W-2 -: COV_W];
      valid_in    = cell_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coverage_ff <= coverage_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_coverage = coverage_ff;

   // every beat leaving the chain gives one result strobe
   `RRCM_ASSERT_NEXT(a_cov_strobe, clock, reset, cell_in.valid, rsp_valid)
   // strictly inside the shape with no outer component, coverage is full
   `RRCM_ASSERT_NEXT(a_cov_deep_inside, clock, reset, (cell_in.valid && (cell_in.root == '0) && cell_in.offset[OFF_W-1]), (rsp_coverage == '1))
   // half a pixel or more outside a square corner gives nothing
   `RRCM_ASSERT_NEXT(a_cov_far_outside, clock, reset, (cell_in.valid && (cell_in.offset == '0) && (cell_in.root >= ROOT_W'(HALF_PIXEL))), (rsp_coverage == '0))

endmodule
